/* src/fdtd_pkg.sv */
// ----------------------------------------------------------------------------
// fdtd_pkg
// shared constants, payload types and the quarter-wave sine table
// ----------------------------------------------------------------------------
package fdtd_pkg;

   localparam int CELLS              = 512;
   localparam int FIELD_BITS         = 24;
   localparam int SINE_TABLE_ENTRIES = 1024;
   localparam int FRAC_BITS          = 16;

   localparam int ADDR_W     = $clog2(CELLS);
   localparam int CNT_W      = $clog2(CELLS + 2);
   localparam int CELL_W     = 9;
   localparam int COEF_W     = 17;
   localparam int START_W    = 10;
   localparam int PHASE_W    = 32;
   localparam int SINE_W     = 18;
   localparam int SINE_IDX_W = $clog2(SINE_TABLE_ENTRIES);
   localparam int QTR_W      = SINE_IDX_W - 2;
   localparam int QTR        = SINE_TABLE_ENTRIES / 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DIELECTRIC_START = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CA_DIELECTRIC    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CB_DIELECTRIC    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PHASE_STEP       = 2'd3;

   // commands
   localparam logic CMD_STEP = 1'b0;
   localparam logic CMD_READ = 1'b1;

   typedef struct packed {
      logic              command;
      logic [CELL_W-1:0] cell_req;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] e_value;
      logic signed [FIELD_BITS-1:0] h_value;
      logic                         saturated;
   } rsp_type;

   typedef logic [16:0] sine_qtr_type [0:QTR];

   // taylor term divisor (2n)(2n+1), truncating
   function automatic longint unsigned taylor_div(longint unsigned t, int n);
      case (n)
         1:       return t / 64'd6;
         2:       return t / 64'd20;
         3:       return t / 64'd42;
         4:       return t / 64'd72;
         5:       return t / 64'd110;
         default: return t / 64'd156;
      endcase
   endfunction

   // first quadrant of the sine, q.16, taylor series to x^13 in q.30
   function automatic sine_qtr_type sine_build();
      sine_qtr_type    tab;
      longint unsigned r;
      longint unsigned x;
      longint unsigned term;
      longint          s;
      longint          res;
      for (int j = 0; j <= QTR; j++) begin
         r    = longint'(j) << (30 - QTR_W);
         x    = (r * 64'd1686629713) >> 30;
         term = x;
         s    = longint'(x);
         for (int n = 1; n <= 6; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = taylor_div(term, n);
            if (n[0]) s = s - longint'(term);
            else s = s + longint'(term);
         end
         res = (s + 8192) >>> 14;
         if (res < 0) res = 0;
         if (res > 65536) res = 65536;
         tab[j] = 17'(res);
      end
      return tab;
   endfunction

   localparam sine_qtr_type SINE_QTR = sine_build();

endpackage

/* src/fdtd_ram.sv */
// ----------------------------------------------------------------------------
// fdtd_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module fdtd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end

endmodule

/* src/fdtd_1d_lossy_dielectric_step.sv */
// ----------------------------------------------------------------------------
// fdtd_1d_lossy_dielectric_step
// 1d yee grid with a lossy dielectric region, e and h held in two rams
// ----------------------------------------------------------------------------
// read item: result strobe follows states ST_READ and ST_OUT once start is taken
// step item: one e sweep and one h sweep, then ST_READ and ST_OUT; each sweep is
//   a streaming read/modify/write over the single ram ports
// one item at a time, busy high until the result strobe; results cannot stall
// reset: synchronous, then a clearing sweep zeroes both rams with busy high;
//   registers take their reset values at once
// ----------------------------------------------------------------------------
module fdtd_1d_lossy_dielectric_step (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  fdtd_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   output fdtd_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [fdtd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fdtd_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import fdtd_pkg::*;

   localparam int FB = FIELD_BITS;

   localparam logic signed [FB-1:0]    FMAX    = {1'b0, {(FB-1){1'b1}}};
   localparam logic signed [FB-1:0]    FMIN    = {1'b1, {(FB-1){1'b0}}};
   localparam logic signed [FB+19:0]   ACC_RND = (FB+20)'(64'sd1 <<< (FRAC_BITS - 1));
   localparam logic [COEF_W-1:0]       CA_ONE  = COEF_W'(65536);
   localparam logic [COEF_W-1:0]       CB_HALF = COEF_W'(32768);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EPASS,
      ST_HPASS,
      ST_READ,
      ST_OUT
   } state_type;

   state_type state_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CELL_W-1:0] cell_ff;

   // configuration registers
   logic [START_W-1:0] dstart_ff;
   logic [COEF_W-1:0]  ca_ff;
   logic [COEF_W-1:0]  cb_ff;
   logic [PHASE_W-1:0] phase_step_ff;

   // step state outside the rams
   logic [PHASE_W-1:0]        phase_ff;
   logic signed [FB-1:0]      hist0_ff, hist1_ff, hist2_ff, hist3_ff;
   logic signed [FB-1:0]      elast_ff;
   logic                      clip_ff;
   logic signed [SINE_W-1:0]  sine_ff;

   // sweep pipeline
   logic                      v1_ff, hp1_ff;
   logic [ADDR_W-1:0]         c1_ff;
   logic                      v2_ff, hp2_ff;
   logic [ADDR_W-1:0]         c2_ff;
   logic signed [FB-1:0]      hprev_ff, eprev_ff, hold_ff;
   logic signed [FB+17:0]     p1_ff;
   logic signed [FB+18:0]     p2_ff;
   logic signed [FB:0]        half_ff;

   logic                      rsp_valid_ff;
   rsp_type                   rsp_ff;

   // ram ports
   logic                      ram_we;
   logic [ADDR_W-1:0]         rd_addr, wr_addr;
   logic signed [FB-1:0]      e_wdata, h_wdata, e_rd, h_rd;
   logic                      e_we, h_we;

   fdtd_ram #(.WIDTH(FB), .DEPTH(CELLS)) u_eram (
      .clock   (clock),
      .wr_en   (e_we),
      .wr_addr (wr_addr),
      .wr_data (e_wdata),
      .rd_addr (rd_addr),
      .rd_data (e_rd)
   );

   fdtd_ram #(.WIDTH(FB), .DEPTH(CELLS)) u_hram (
      .clock   (clock),
      .wr_en   (h_we),
      .wr_addr (wr_addr),
      .wr_data (h_wdata),
      .rd_addr (rd_addr),
      .rd_data (h_rd)
   );

   logic in_pass, rd_issue, accept;
   assign in_pass  = (state_ff == ST_EPASS) || (state_ff == ST_HPASS);
   assign rd_issue = in_pass && (cnt_ff < CNT_W'(CELLS));
   assign rd_addr  = in_pass ? cnt_ff[ADDR_W-1:0] : ADDR_W'(cell_ff);
   assign accept   = start && (state_ff == ST_IDLE);

   // sine lookup, quarter table mirrored and negated by quadrant
   logic [SINE_IDX_W-1:0] s_idx;
   logic [1:0]            s_quad;
   logic [QTR_W:0]        s_j;
   logic [16:0]           s_mag;
   logic signed [SINE_W-1:0] s_val;
   always_comb begin
      s_idx  = phase_ff[PHASE_W-1 -: SINE_IDX_W];
      s_quad = s_idx[SINE_IDX_W-1 -: 2];
      s_j    = s_quad[0] ? ((QTR_W+1)'(QTR) - {1'b0, s_idx[QTR_W-1:0]})
                         : {1'b0, s_idx[QTR_W-1:0]};
      s_mag  = SINE_QTR[s_j];
      s_val  = s_quad[1] ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
   end

   // stage 1: coefficient select and products (e sweep), half difference (h sweep)
   logic                     dielectric;
   logic [COEF_W-1:0]        ca_sel, cb_sel;
   logic signed [FB:0]       hdiff, ediff;
   logic signed [FB+1:0]     ediff1;
   always_comb begin
      dielectric = (c1_ff >= dstart_ff);
      ca_sel     = dielectric ? ca_ff : CA_ONE;
      cb_sel     = dielectric ? cb_ff : CB_HALF;
      hdiff      = hprev_ff - h_rd;
      ediff      = eprev_ff - e_rd;
      ediff1     = ediff + $signed((FB+2)'(1));
   end

   // stage 2: round, saturate, source injection, h accumulate
   logic signed [FB+19:0] acc;
   logic signed [FB+3:0]  e_rnd;
   logic signed [FB-1:0]  e_sat1, e_fin;
   logic signed [FB+2:0]  e_src;
   logic                  clip1, clip2;
   logic signed [FB+1:0]  h_sum;
   logic signed [FB-1:0]  h_fin;
   logic                  cliph;
   logic                  is_src, is_first, is_last, is_pen;
   always_comb begin
      acc    = p1_ff + p2_ff + ACC_RND;
      e_rnd  = acc[FB+19:FRAC_BITS];
      clip1  = (e_rnd > FMAX) || (e_rnd < FMIN);
      e_sat1 = (e_rnd > FMAX) ? FMAX : (e_rnd < FMIN) ? FMIN : e_rnd[FB-1:0];
      is_first = (c2_ff == '0);
      is_src   = (c2_ff == ADDR_W'(1));
      is_last  = (c2_ff == ADDR_W'(CELLS - 1));
      is_pen   = (c2_ff == ADDR_W'(CELLS - 2));
      e_src  = e_sat1 + sine_ff;
      clip2  = is_src && ((e_src > FMAX) || (e_src < FMIN));
      e_fin  = e_sat1;
      if (is_src) begin
         e_fin = (e_src > FMAX) ? FMAX : (e_src < FMIN) ? FMIN : e_src[FB-1:0];
      end
      h_sum  = hold_ff + half_ff;
      cliph  = (h_sum > FMAX) || (h_sum < FMIN);
      h_fin  = (h_sum > FMAX) ? FMAX : (h_sum < FMIN) ? FMIN : h_sum[FB-1:0];
   end

   // write port: clearing sweep or stage 2 of a sweep
   always_comb begin
      ram_we  = (state_ff == ST_CLEAR);
      wr_addr = ram_we ? cnt_ff[ADDR_W-1:0] : c2_ff;
      e_we    = ram_we || (v2_ff && !hp2_ff);
      h_we    = ram_we || (v2_ff && hp2_ff);
      h_wdata = ram_we ? '0 : h_fin;
      if (ram_we) e_wdata = '0;
      else if (is_first) e_wdata = hist0_ff;        // left boundary takes delayed e[1]
      else if (is_last) e_wdata = hist3_ff;         // right boundary takes delayed e[n-2]
      else e_wdata = e_fin;
   end

   always_ff @(posedge clock) begin
      sine_ff <= s_val;
      rsp_valid_ff <= 1'b0;

      // stage 1
      v1_ff  <= rd_issue;
      hp1_ff <= (state_ff == ST_HPASS);
      c1_ff  <= cnt_ff[ADDR_W-1:0];
      if (v1_ff) begin
         hprev_ff <= h_rd;
         eprev_ff <= e_rd;
         p1_ff    <= $signed({1'b0, ca_sel}) * e_rd;
         p2_ff    <= $signed({1'b0, cb_sel}) * hdiff;
         half_ff  <= ediff1[FB+1:1];
         hold_ff  <= hprev_ff;
      end
      v2_ff  <= v1_ff && (!hp1_ff || (c1_ff != '0));
      hp2_ff <= hp1_ff;
      c2_ff  <= hp1_ff ? (c1_ff - ADDR_W'(1)) : c1_ff;

      // stage 2 side effects: boundary history and clip flag
      if (v2_ff && !hp2_ff) begin
         if (!is_first && (clip1 || clip2)) clip_ff <= 1'b1;
         if (is_src) begin
            hist0_ff <= hist1_ff;
            hist1_ff <= e_fin;
         end
         if (is_pen) elast_ff <= e_fin;
         if (is_last) begin
            hist3_ff <= hist2_ff;
            hist2_ff <= elast_ff;
         end
      end
      if (v2_ff && hp2_ff && cliph) clip_ff <= 1'b1;

      // configuration writes
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_DIELECTRIC_START: dstart_ff     <= csr_wdata[START_W-1:0];
            REG_CA_DIELECTRIC:    ca_ff         <= csr_wdata[COEF_W-1:0];
            REG_CB_DIELECTRIC:    cb_ff         <= csr_wdata[COEF_W-1:0];
            REG_PHASE_STEP:       phase_step_ff <= csr_wdata[PHASE_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(CELLS - 1)) state_ff <= ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               cell_ff <= req_data.cell_req;
               cnt_ff  <= '0;
               if (req_data.command == CMD_STEP) begin
                  phase_ff <= phase_ff + phase_step_ff;
                  state_ff <= ST_EPASS;
               end else begin
                  state_ff <= ST_READ;
               end
            end
         end
         ST_EPASS: begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(CELLS + 1)) begin
               cnt_ff   <= '0;
               state_ff <= ST_HPASS;
            end
         end
         ST_HPASS: begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(CELLS + 1)) state_ff <= ST_READ;
         end
         ST_READ: begin
            state_ff <= ST_OUT;
         end
         ST_OUT: begin
            // cells past the grid report zero fields
            if (int'(cell_ff) < CELLS) begin
               rsp_ff.e_value <= e_rd;
               rsp_ff.h_value <= h_rd;
            end else begin
               rsp_ff.e_value <= '0;
               rsp_ff.h_value <= '0;
            end
            rsp_ff.saturated <= clip_ff;
            rsp_valid_ff     <= 1'b1;
            state_ff         <= ST_IDLE;
         end
         default: state_ff <= ST_IDLE;
      endcase

      if (reset) begin
         state_ff      <= ST_CLEAR;
         cnt_ff        <= '0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         phase_ff      <= '0;
         hist0_ff      <= '0;
         hist1_ff      <= '0;
         hist2_ff      <= '0;
         hist3_ff      <= '0;
         clip_ff       <= 1'b0;
         dstart_ff     <= START_W'(256);
         ca_ff         <= COEF_W'(64314);
         cb_ff         <= COEF_W'(8115);
         phase_step_ff <= PHASE_W'(50107952);
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* sim/fdtd_grid_checker.sv */
// ----------------------------------------------------------------------------
// fdtd_grid_checker
// shadow copy of the 1d lossy yee grid, predicts every result item and
// compares it field by field with what the block returns
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fdtd_grid_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  fdtd_pkg::req_type               req_data,
   input  logic                            rsp_valid,
   input  fdtd_pkg::rsp_type               rsp_data,
   input  logic                            csr_wr_en,
   input  logic [fdtd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fdtd_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              fail_count,
   output int                              pending
);
   import fdtd_pkg::*;

   localparam longint FIELD_MAX = (64'sd1 <<< (FIELD_BITS - 1)) - 1;
   localparam longint FIELD_MIN = -FIELD_MAX - 1;

   longint             grid_e [CELLS];
   longint             grid_h [CELLS];
   longint             edge_mem [4];
   longint             sine_lut [SINE_TABLE_ENTRIES];
   logic [PHASE_W-1:0] phase_acc;
   logic               clip_seen;
   logic [START_W-1:0] diel_start;
   logic [COEF_W-1:0]  diel_ca;
   logic [COEF_W-1:0]  diel_cb;
   logic [PHASE_W-1:0] phase_inc;
   rsp_type            field_queue [$];

   assign pending = field_queue.size();

   function automatic longint clip_field(longint v);
      if (v > FIELD_MAX) begin
         clip_seen = 1'b1;
         return FIELD_MAX;
      end
      if (v < FIELD_MIN) begin
         clip_seen = 1'b1;
         return FIELD_MIN;
      end
      return v;
   endfunction

   // full-cycle table, quadrant folding and taylor series in q.30
   function automatic longint sine_sample(int k);
      longint unsigned frac, off, ang, term;
      longint          acc, res;
      int              quad;
      frac = longint'(k) << 22;
      quad = int'(frac >> 30) & 3;
      off  = frac & 64'h3FFF_FFFF;
      if (quad[0]) off = 64'h4000_0000 - off;
      ang  = (off * 64'd1686629713) >> 30;
      term = ang;
      acc  = longint'(ang);
      for (int n = 1; n <= 6; n++) begin
         term = (term * ang) >> 30;
         term = (term * ang) >> 30;
         term = term / longint'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) acc -= longint'(term);
         else acc += longint'(term);
      end
      res = (acc + 8192) >>> 14;
      if (res < 0) res = 0;
      if (res > 65536) res = 65536;
      return (quad >= 2) ? -res : res;
   endfunction

   function automatic void advance_grid();
      longint ca, cb, acc, d;
      int     idx;
      phase_acc = phase_acc + phase_inc;
      for (int i = 1; i < CELLS; i++) begin
         ca = (i >= diel_start) ? longint'(diel_ca) : 65536;
         cb = (i >= diel_start) ? longint'(diel_cb) : 32768;
         acc = ca * grid_e[i] + cb * (grid_h[i-1] - grid_h[i]);
         grid_e[i] = clip_field((acc + 32768) >>> FRAC_BITS);
      end
      idx = int'(phase_acc[PHASE_W-1 -: SINE_IDX_W]);
      grid_e[1] = clip_field(grid_e[1] + sine_lut[idx]);
      // absorbing edges, two steps of delay at each end
      grid_e[0]       = edge_mem[0];
      edge_mem[0]     = edge_mem[1];
      edge_mem[1]     = grid_e[1];
      grid_e[CELLS-1] = edge_mem[3];
      edge_mem[3]     = edge_mem[2];
      edge_mem[2]     = grid_e[CELLS-2];
      for (int i = 0; i < CELLS - 1; i++) begin
         d = grid_e[i] - grid_e[i+1];
         grid_h[i] = clip_field(grid_h[i] + ((d + 1) >>> 1));
      end
   endfunction

   initial begin
      for (int k = 0; k < SINE_TABLE_ENTRIES; k++) sine_lut[k] = sine_sample(k);
   end

   always @(posedge clock) begin
      rsp_type want;
      int      cell_idx;
      if (reset) begin
         fail_count = 0;
         foreach (grid_e[i]) grid_e[i] = 0;
         foreach (grid_h[i]) grid_h[i] = 0;
         foreach (edge_mem[i]) edge_mem[i] = 0;
         phase_acc  = '0;
         clip_seen  = 1'b0;
         diel_start = 10'd256;
         diel_ca    = 17'd64314;
         diel_cb    = 17'd8115;
         phase_inc  = 32'd50107952;
         field_queue.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_DIELECTRIC_START: diel_start = csr_wdata[START_W-1:0];
               REG_CA_DIELECTRIC:    diel_ca    = csr_wdata[COEF_W-1:0];
               REG_CB_DIELECTRIC:    diel_cb    = csr_wdata[COEF_W-1:0];
               REG_PHASE_STEP:       phase_inc  = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (field_queue.size() == 0) begin
               $error("result item with nothing expected");
               fail_count++;
            end else begin
               want = field_queue.pop_front();
               if (rsp_data.e_value !== want.e_value) begin
                  $error("e_value expected %0d got %0d", want.e_value, rsp_data.e_value);
                  fail_count++;
               end
               if (rsp_data.h_value !== want.h_value) begin
                  $error("h_value expected %0d got %0d", want.h_value, rsp_data.h_value);
                  fail_count++;
               end
               if (rsp_data.saturated !== want.saturated) begin
                  $error("saturated expected %0b got %0b", want.saturated,
                         rsp_data.saturated);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            if (req_data.command == CMD_STEP) advance_grid();
            cell_idx = int'(req_data.cell_req);
            want.e_value   = (cell_idx < CELLS) ? grid_e[cell_idx][FIELD_BITS-1:0] : '0;
            want.h_value   = (cell_idx < CELLS) ? grid_h[cell_idx][FIELD_BITS-1:0] : '0;
            want.saturated = clip_seen;
            field_queue.push_back(want);
         end
      end
   end

endmodule

/* sim/tb_fdtd_1d_lossy_dielectric_step.sv */
// ----------------------------------------------------------------------------
// tb_fdtd_1d_lossy_dielectric_step
// drives step and read items with random gaps across several register
// settings; the checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fdtd_1d_lossy_dielectric_step;
   import fdtd_pkg::*;

   localparam int CYCLE_LIMIT = 3_000_000;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req_data;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    pending;
   int                    cycle_count;
   int                    steps_sent;
   int                    reads_sent;

   fdtd_1d_lossy_dielectric_step uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   fdtd_grid_checker grid_check (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog, far above the slowest legal run including the clearing sweep
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // one item: random gap first, start stays high when the gap is zero
   task automatic send_item(input logic cmd, input logic [CELL_W-1:0] cell_sel);
      int gap;
      gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6));
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= '{command: cmd, cell_req: cell_sel};
      @(posedge clock);
      while (busy) @(posedge clock);
      if (cmd == CMD_STEP) steps_sent++;
      else reads_sent++;
   endtask

   // let the grid drain completely before touching a register
   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_all(input logic [CSR_DATA_W-1:0] ds, input logic [CSR_DATA_W-1:0] ca,
                          input logic [CSR_DATA_W-1:0] cb, input logic [CSR_DATA_W-1:0] ps);
      wait_idle();
      write_reg(REG_DIELECTRIC_START, ds);
      write_reg(REG_CA_DIELECTRIC, ca);
      write_reg(REG_CB_DIELECTRIC, cb);
      write_reg(REG_PHASE_STEP, ps);
   endtask

   // cells cluster round the source, the edges and the dielectric boundary
   function automatic logic [CELL_W-1:0] pick_cell();
      case ($urandom_range(0, 4))
         0:       return CELL_W'($urandom_range(0, 4));
         1:       return CELL_W'($urandom_range(CELLS - 4, CELLS - 1));
         2:       return CELL_W'($urandom_range(240, 270));
         default: return CELL_W'($urandom_range(0, CELLS - 1));
      endcase
   endfunction

   task automatic random_burst(input int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 9) < 6) send_item(CMD_STEP, pick_cell());
         else send_item(CMD_READ, pick_cell());
      end
   endtask

   initial begin
      steps_sent = 0;
      reads_sent = 0;
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      csr_wr_en  = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: reads on a fresh grid, then steps watching source and edges
      send_item(CMD_READ, 9'd0);
      send_item(CMD_READ, 9'd511);
      send_item(CMD_STEP, 9'd1);
      send_item(CMD_STEP, 9'd0);
      send_item(CMD_STEP, 9'd2);
      send_item(CMD_READ, 9'd1);
      send_item(CMD_STEP, 9'd511);
      send_item(CMD_STEP, 9'd510);
      send_item(CMD_READ, 9'h155);
      send_item(CMD_READ, 9'h0AA);
      send_item(CMD_STEP, 9'd256);
      send_item(CMD_STEP, 9'd255);

      // whole grid dielectric, coefficients at zero, half-cycle phase step
      set_all(32'd0, 32'd0, 32'd0, 32'h8000_0000);
      send_item(CMD_STEP, 9'd1);
      send_item(CMD_STEP, 9'd2);
      send_item(CMD_READ, 9'd0);
      // no dielectric cell at all: start at the grid size and beyond it
      set_all(32'd512, 32'd65536, 32'd65536, 32'hFFFF_FFFF);
      send_item(CMD_STEP, 9'd1);
      send_item(CMD_STEP, 9'd511);
      set_all(32'd1023, 32'd131071, 32'd131071, 32'd0);
      send_item(CMD_STEP, 9'd1);
      send_item(CMD_READ, 9'd3);

      // random phases at reset-like, boundary and random settings
      set_all(32'd256, 32'd64314, 32'd8115, 32'd50107952);
      random_burst(120);
      set_all(32'd1, 32'd65536, 32'd65536, 32'h0400_0000);
      random_burst(90);
      set_all($urandom_range(0, 1023), $urandom_range(0, 65536), $urandom_range(0, 65536),
              $urandom());
      random_burst(90);
      set_all(32'd400, 32'd60000, 32'd20000, 32'h1234_5678);
      random_burst(90);
      // oversized coefficients drive the fields into clipping
      set_all(32'd300, 32'd131071, 32'd98304, 32'hFFFF_FFFF);
      random_burst(130);

      wait_idle();
      repeat (20) @(posedge clock);
      $display("covered %0d step items and %0d read items over nine register settings",
               steps_sent, reads_sent);
      $display("settings reached zero and oversized coefficients and an empty dielectric");
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* files.f */
src/fdtd_pkg.sv
src/fdtd_ram.sv
src/fdtd_1d_lossy_dielectric_step.sv
sim/fdtd_grid_checker.sv
sim/tb_fdtd_1d_lossy_dielectric_step.sv
